@@ rtl/bcs_pkg.sv @@
// bcs_pkg: shared widths, latencies and types of the box/circle separating-axis test.
// Has no dependencies. The files that use it refer to it by scoped names.
package bcs_pkg;

  // axis normalisation: the larger component is brought into [2^29, 2^30)
  localparam int unsigned U_W        = 30;
  localparam int unsigned NORM_TOP   = 29;
  localparam int unsigned SQ_W       = 2 * U_W;
  localparam int unsigned SUM_W      = SQ_W + 1;

  // integer square root, ISQ_PER digit steps in each stage and fewer in the last
  localparam int unsigned ISQ_W      = SUM_W + 1;
  localparam int unsigned LEN_W      = 31;
  localparam int unsigned ISQ_STEPS  = 31;
  localparam int unsigned ISQ_PER    = 4;
  localparam int unsigned ISQ_STAGES = (ISQ_STEPS + ISQ_PER - 1) / ISQ_PER;

  // restoring division of the scaled component by the length
  localparam int unsigned NUM_W      = 46;
  localparam int unsigned QB         = 17;
  localparam int unsigned REM_W      = 32;
  localparam int unsigned DIV_PER    = 4;
  localparam int unsigned DIV_STAGES = (QB + DIV_PER - 1) / DIV_PER;

  localparam int unsigned AXIS_W     = 16;
  localparam int unsigned OVL_W      = 31;
  localparam logic [OVL_W-1:0] OVL_MAX = {OVL_W{1'b1}};
  localparam logic [14:0]      Q_MAX   = 15'h7fff;

  // cycle counts: front end (distances, nearest vertex), one axis lane, back end
  localparam int unsigned FRONT_LAT  = 6;
  localparam int unsigned LANE_LAT   = 4 + ISQ_STAGES + 1 + DIV_STAGES + 1;
  localparam int unsigned BACK_LAT   = 7;
  localparam int unsigned LAT        = FRONT_LAT + LANE_LAT + BACK_LAT;

  typedef struct packed {
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic                     ok;
  } axis_t;

endpackage

@@ rtl/bcs_delay.sv @@
// bcs_delay: fixed-length register shift line for payload alignment.
// No dependencies.
module bcs_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= d_i;
    for (int i = 1; i < DEPTH; i++) begin
      pipe_q[i] <= pipe_q[i-1];
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

@@ rtl/bcs_sqr.sv @@
// bcs_sqr: two-stage unsigned squarer built from half-width partial products.
// No dependencies.
module bcs_sqr #(
  parameter int unsigned AW = 33
) (
  input  logic            clk_i,
  input  logic [AW-1:0]   a_i,
  output logic [2*AW-1:0] sq_o
);

  localparam int unsigned LW   = (AW + 1) / 2;
  localparam int unsigned HW   = AW - LW;
  localparam int unsigned HH_W = 2 * HW;
  localparam int unsigned HL_W = HW + LW;
  localparam int unsigned LL_W = 2 * LW;
  localparam int unsigned SQW  = 2 * AW;

  logic [LW-1:0]   al;
  logic [HW-1:0]   ah;
  logic [HH_W-1:0] hh_q;
  logic [HL_W-1:0] hl_q;
  logic [LL_W-1:0] ll_q;
  logic [SQW-1:0]  sq_q;

  assign al = a_i[LW-1:0];
  assign ah = a_i[AW-1:LW];

  always_ff @(posedge clk_i) begin
    hh_q <= HH_W'(ah) * HH_W'(ah);
    hl_q <= HL_W'(ah) * HL_W'(al);
    ll_q <= LL_W'(al) * LL_W'(al);
    // a^2 = ah^2 << 2L + 2 ah al << L + al^2
    sq_q <= (SQW'(hh_q) << LL_W) + (SQW'(hl_q) << (LW + 1)) + SQW'(ll_q);
  end

  assign sq_o = sq_q;

endmodule

@@ rtl/bcs_isqrt.sv @@
// bcs_isqrt: pipelined floor square root, a few digit steps in each stage.
// Depends on bcs_pkg.
module bcs_isqrt (
  input  logic                        clk_i,
  input  logic [bcs_pkg::SUM_W-1:0]   s_i,
  output logic [bcs_pkg::LEN_W-1:0]   root_o
);

  localparam int unsigned W = bcs_pkg::ISQ_W;
  localparam logic [W-1:0] TOP_BIT = W'(1) << (2 * (bcs_pkg::ISQ_STEPS - 1));

  logic [W-1:0] r_q [bcs_pkg::ISQ_STAGES];
  logic [W-1:0] s_q [bcs_pkg::ISQ_STAGES];

  for (genvar g = 0; g < bcs_pkg::ISQ_STAGES; g++) begin : g_stage
    logic [W-1:0] r_in, s_in, r_d, s_d;

    if (g == 0) begin : g_first
      assign r_in = '0;
      assign s_in = W'(s_i);
    end else begin : g_next
      assign r_in = r_q[g-1];
      assign s_in = s_q[g-1];
    end

    always_comb begin
      logic [W-1:0] bitv;
      r_d  = r_in;
      s_d  = s_in;
      bitv = '0;
      for (int j = 0; j < bcs_pkg::ISQ_PER; j++) begin
        if (g * bcs_pkg::ISQ_PER + j < bcs_pkg::ISQ_STEPS) begin
          bitv = TOP_BIT >> (2 * (g * bcs_pkg::ISQ_PER + j));
          if (s_d >= r_d + bitv) begin
            s_d = s_d - (r_d + bitv);
            r_d = (r_d >> 1) + bitv;
          end else begin
            r_d = r_d >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      r_q[g] <= r_d;
      s_q[g] <= s_d;
    end
  end

  assign root_o = r_q[bcs_pkg::ISQ_STAGES-1][bcs_pkg::LEN_W-1:0];

endmodule

@@ rtl/bcs_div.sv @@
// bcs_div: pipelined restoring divider, round(u * 2^15 / len) for one component.
// Depends on bcs_pkg.
module bcs_div (
  input  logic                      clk_i,
  input  logic [bcs_pkg::U_W-1:0]   u_i,
  input  logic [bcs_pkg::LEN_W-1:0] len_i,
  output logic [bcs_pkg::QB-1:0]    q_o
);

  localparam int unsigned NW = bcs_pkg::NUM_W;
  localparam int unsigned RW = bcs_pkg::REM_W;
  localparam int unsigned QW = bcs_pkg::QB;
  localparam int unsigned NS = bcs_pkg::DIV_STAGES;

  logic [NW-1:0]             num_q;
  logic [bcs_pkg::LEN_W-1:0] den_q;
  logic [RW-1:0]             rem_q [NS];
  logic [QW-1:0]             quo_q [NS];
  logic [QW-1:0]             nb_q  [NS];
  logic [bcs_pkg::LEN_W-1:0] dn_q  [NS];

  // numerator with half the divisor added for round half up
  always_ff @(posedge clk_i) begin
    num_q <= (NW'(u_i) << 15) + NW'(len_i >> 1);
    den_q <= len_i;
  end

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [RW-1:0]             rem_in, rem_d;
    logic [QW-1:0]             quo_in, quo_d, nb_in, nb_d;
    logic [bcs_pkg::LEN_W-1:0] dn_in;

    if (g == 0) begin : g_first
      assign rem_in = RW'(num_q[NW-1:QW]);
      assign quo_in = '0;
      assign nb_in  = num_q[QW-1:0];
      assign dn_in  = den_q;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign quo_in = quo_q[g-1];
      assign nb_in  = nb_q[g-1];
      assign dn_in  = dn_q[g-1];
    end

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      nb_d  = nb_in;
      for (int j = 0; j < bcs_pkg::DIV_PER; j++) begin
        if (g * bcs_pkg::DIV_PER + j < QW) begin
          rem_d = {rem_d[RW-2:0], nb_d[QW-1]};
          nb_d  = nb_d << 1;
          if (rem_d >= RW'(dn_in)) begin
            rem_d = rem_d - RW'(dn_in);
            quo_d = {quo_d[QW-2:0], 1'b1};
          end else begin
            quo_d = {quo_d[QW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g] <= rem_d;
      quo_q[g] <= quo_d;
      nb_q[g]  <= nb_d;
      dn_q[g]  <= dn_in;
    end
  end

  assign q_o = quo_q[NS-1];

endmodule

@@ rtl/bcs_axis.sv @@
// bcs_axis: one axis lane, turns a direction vector into a Q1.15 unit axis.
// Depends on bcs_pkg, bcs_delay, bcs_isqrt and bcs_div.
module bcs_axis #(
  parameter int unsigned DW = 33
) (
  input  logic                 clk_i,
  input  logic signed [DW-1:0] dx_i,
  input  logic signed [DW-1:0] dy_i,
  output bcs_pkg::axis_t       axis_o
);

  localparam int unsigned UW    = bcs_pkg::U_W;
  localparam int unsigned EXT_W = DW + UW;
  localparam int unsigned SW    = $clog2(EXT_W);

  // flags: {non-zero, x negative, y negative}
  logic [DW-1:0] ux, uy, m;
  logic [SW-1:0] pos;
  logic [DW-1:0] ux1_q, uy1_q;
  logic [SW-1:0] sh1_q;
  logic          rt1_q;
  logic [2:0]    f1_q, f2_q, fl_w, ff_w;
  logic [EXT_W-1:0] uxs, uys;
  logic [UW-1:0] ux2_q, uy2_q, uxl_w, uyl_w;
  logic [bcs_pkg::SQ_W-1:0]  sqx_q, sqy_q;
  logic [bcs_pkg::SUM_W-1:0] sum_q;
  logic [bcs_pkg::LEN_W-1:0] len_w;
  logic [bcs_pkg::QB-1:0]    qx_w, qy_w;
  bcs_pkg::axis_t            axis_q;

  always_comb begin
    ux  = dx_i[DW-1] ? DW'(-dx_i) : DW'(dx_i);
    uy  = dy_i[DW-1] ? DW'(-dy_i) : DW'(dy_i);
    m   = (ux > uy) ? ux : uy;
    pos = '0;
    for (int i = 0; i < DW; i++) begin
      if (m[i]) pos = SW'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    ux1_q <= ux;
    uy1_q <= uy;
    rt1_q <= (pos > SW'(bcs_pkg::NORM_TOP));
    sh1_q <= (pos > SW'(bcs_pkg::NORM_TOP)) ? pos - SW'(bcs_pkg::NORM_TOP)
                                             : SW'(bcs_pkg::NORM_TOP) - pos;
    f1_q  <= {(m != '0), dx_i[DW-1], dy_i[DW-1]};
  end

  // right shift truncates, left shift is exact
  always_comb begin
    uxs = rt1_q ? (EXT_W'(ux1_q) >> sh1_q) : (EXT_W'(ux1_q) << sh1_q);
    uys = rt1_q ? (EXT_W'(uy1_q) >> sh1_q) : (EXT_W'(uy1_q) << sh1_q);
  end

  always_ff @(posedge clk_i) begin
    ux2_q <= uxs[UW-1:0];
    uy2_q <= uys[UW-1:0];
    f2_q  <= f1_q;
    sqx_q <= bcs_pkg::SQ_W'(ux2_q) * bcs_pkg::SQ_W'(ux2_q);
    sqy_q <= bcs_pkg::SQ_W'(uy2_q) * bcs_pkg::SQ_W'(uy2_q);
    sum_q <= bcs_pkg::SUM_W'(sqx_q) + bcs_pkg::SUM_W'(sqy_q);
  end

  bcs_isqrt u_isqrt (
    .clk_i  (clk_i),
    .s_i    (sum_q),
    .root_o (len_w)
  );

  bcs_delay #(
    .WIDTH (2 * UW + 3),
    .DEPTH (2 + bcs_pkg::ISQ_STAGES)
  ) u_dly_u (
    .clk_i (clk_i),
    .d_i   ({ux2_q, uy2_q, f2_q}),
    .q_o   ({uxl_w, uyl_w, fl_w})
  );

  bcs_div u_div_x (
    .clk_i (clk_i),
    .u_i   (uxl_w),
    .len_i (len_w),
    .q_o   (qx_w)
  );

  bcs_div u_div_y (
    .clk_i (clk_i),
    .u_i   (uyl_w),
    .len_i (len_w),
    .q_o   (qy_w)
  );

  bcs_delay #(
    .WIDTH (3),
    .DEPTH (1 + bcs_pkg::DIV_STAGES)
  ) u_dly_f (
    .clk_i (clk_i),
    .d_i   (fl_w),
    .q_o   (ff_w)
  );

  always_ff @(posedge clk_i) begin
    logic [14:0] cx, cy;
    cx = (qx_w > bcs_pkg::QB'(bcs_pkg::Q_MAX)) ? bcs_pkg::Q_MAX : qx_w[14:0];
    cy = (qy_w > bcs_pkg::QB'(bcs_pkg::Q_MAX)) ? bcs_pkg::Q_MAX : qy_w[14:0];
    axis_q.ok <= ff_w[2];
    axis_q.x  <= !ff_w[2] ? '0 : (ff_w[1] ? -$signed({1'b0, cx}) : $signed({1'b0, cx}));
    axis_q.y  <= !ff_w[2] ? '0 : (ff_w[0] ? -$signed({1'b0, cy}) : $signed({1'b0, cy}));
  end

  assign axis_o = axis_q;

endmodule

@@ rtl/box_circle_sat_mtv_top.sv @@
// box_circle_sat_mtv_top: separating-axis test of a 2D box against a circle.
// Depends on bcs_pkg, bcs_delay, bcs_sqr and bcs_axis.
//
// Use: present the four box vertices, the circle centre and radius (signed
// Q16.16, radius unsigned) and raise start_i for one cycle. busy_o is always
// low, so a new test is taken on every cycle that start_i is high.
// Each test gives exactly one result beat:
// done_o is high for a single cycle with hit_o, overlap_o and the Q1.15
// axis of smallest overlap. No hit gives zero overlap and a zero axis.
// Throughput is one test per cycle. The pipeline runs through distances and
// nearest-vertex search in front, then the axis lanes (a pipelined square
// root of 8 stages and a pipelined divider), then projection and overlap
// selection behind.
// The receiver cannot stall: a result is shown once and must be taken.
// Reset clears the valid line only; tests in flight are dropped and no
// result appears until a new test is taken. There is no clearing pass.
module box_circle_sat_mtv_top #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] box_v0_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_v0_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_v1_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_v1_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_v2_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_v2_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_v3_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_v3_y_i,
  input  logic signed [COORD_WIDTH-1:0] circle_x_i,
  input  logic signed [COORD_WIDTH-1:0] circle_y_i,
  input  logic        [COORD_WIDTH-2:0] circle_radius_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [bcs_pkg::OVL_W-1:0]     overlap_o,
  output logic signed [bcs_pkg::AXIS_W-1:0] axis_x_o,
  output logic signed [bcs_pkg::AXIS_W-1:0] axis_y_o
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned RW   = CW - 1;
  localparam int unsigned DW   = CW + 1;
  localparam int unsigned DSW  = 2 * DW + 1;
  localparam int unsigned PW   = CW + bcs_pkg::AXIS_W;
  localparam int unsigned JW   = CW + 2;
  localparam int unsigned EW   = CW + 3;
  localparam int unsigned OW   = CW + 4;
  localparam int unsigned CMPW = (OW > 32) ? OW : 32;
  localparam int unsigned AXB  = $bits(bcs_pkg::axis_t);
  localparam int unsigned LAT  = bcs_pkg::LAT;
  localparam logic signed [CMPW-1:0] OVL_LIM = CMPW'(bcs_pkg::OVL_MAX);

  // ---------------- valid line
  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start_i};
    end
  end

  assign busy_o = 1'b0;
  assign done_o = vld_q[LAT-1];

  // ---------------- front end: vertex-to-centre vectors and box edges
  logic signed [CW-1:0] vx [4];
  logic signed [CW-1:0] vy [4];

  assign vx[0] = box_v0_x_i;  assign vy[0] = box_v0_y_i;
  assign vx[1] = box_v1_x_i;  assign vy[1] = box_v1_y_i;
  assign vx[2] = box_v2_x_i;  assign vy[2] = box_v2_y_i;
  assign vx[3] = box_v3_x_i;  assign vy[3] = box_v3_y_i;

  logic signed [DW-1:0] dcx_q [4];
  logic signed [DW-1:0] dcy_q [4];
  logic signed [DW-1:0] ex_q  [2];
  logic signed [DW-1:0] ey_q  [2];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      dcx_q[i] <= DW'(circle_x_i) - DW'(vx[i]);
      dcy_q[i] <= DW'(circle_y_i) - DW'(vy[i]);
    end
    for (int i = 0; i < 2; i++) begin
      ex_q[i] <= DW'(vx[i+1]) - DW'(vx[i]);
      ey_q[i] <= DW'(vy[i+1]) - DW'(vy[i]);
    end
  end

  logic [2*DW-1:0] sqx_w [4];
  logic [2*DW-1:0] sqy_w [4];

  for (genvar i = 0; i < 4; i++) begin : g_dist
    logic [DW-1:0] mx, my;
    assign mx = dcx_q[i][DW-1] ? DW'(-dcx_q[i]) : DW'(dcx_q[i]);
    assign my = dcy_q[i][DW-1] ? DW'(-dcy_q[i]) : DW'(dcy_q[i]);

    bcs_sqr #(.AW(DW)) u_sqr_x (.clk_i(clk_i), .a_i(mx), .sq_o(sqx_w[i]));
    bcs_sqr #(.AW(DW)) u_sqr_y (.clk_i(clk_i), .a_i(my), .sq_o(sqy_w[i]));
  end

  logic [DSW-1:0] d_q [4];
  logic [DSW-1:0] d01_q, d23_q;
  logic           i01_q, i23_q;

  // nearest vertex, ties kept by the lower index
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      d_q[i] <= DSW'(sqx_w[i]) + DSW'(sqy_w[i]);
    end
    i01_q <= (d_q[1] < d_q[0]);
    d01_q <= (d_q[1] < d_q[0]) ? d_q[1] : d_q[0];
    i23_q <= (d_q[3] < d_q[2]);
    d23_q <= (d_q[3] < d_q[2]) ? d_q[3] : d_q[2];
  end

  logic [11:0][DW-1:0] fp_w, fpd_w;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fp_w[i]   = dcx_q[i];
      fp_w[4+i] = dcy_q[i];
    end
    fp_w[8]  = ex_q[0];
    fp_w[9]  = ey_q[0];
    fp_w[10] = ex_q[1];
    fp_w[11] = ey_q[1];
  end

  bcs_delay #(.WIDTH(12 * DW), .DEPTH(4)) u_dly_front (
    .clk_i (clk_i),
    .d_i   (fp_w),
    .q_o   (fpd_w)
  );

  logic [1:0]           nv;
  logic signed [DW-1:0] lx_q [3];
  logic signed [DW-1:0] ly_q [3];

  assign nv = (d23_q < d01_q) ? {1'b1, i23_q} : {1'b0, i01_q};

  always_ff @(posedge clk_i) begin
    lx_q[0] <= fpd_w[8];
    ly_q[0] <= fpd_w[9];
    lx_q[1] <= fpd_w[10];
    ly_q[1] <= fpd_w[11];
    lx_q[2] <= fpd_w[4'(nv)];
    ly_q[2] <= fpd_w[4'(nv) + 4'd4];
  end

  // ---------------- axis lanes
  bcs_pkg::axis_t ax_w [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    bcs_axis #(.DW(DW)) u_axis (
      .clk_i  (clk_i),
      .dx_i   (lx_q[k]),
      .dy_i   (ly_q[k]),
      .axis_o (ax_w[k])
    );
  end

  // ---------------- shape data aligned to the lane outputs, the radius and the axes to later stages
  logic [9:0][CW-1:0] cp_w, cpd_w;
  logic [RW-1:0]      r_w;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cp_w[2*i]   = vx[i];
      cp_w[2*i+1] = vy[i];
    end
    cp_w[8] = circle_x_i;
    cp_w[9] = circle_y_i;
  end

  bcs_delay #(
    .WIDTH (10 * CW),
    .DEPTH (bcs_pkg::FRONT_LAT + bcs_pkg::LANE_LAT)
  ) u_dly_coord (
    .clk_i (clk_i),
    .d_i   (cp_w),
    .q_o   (cpd_w)
  );

  bcs_delay #(
    .WIDTH (RW),
    .DEPTH (bcs_pkg::FRONT_LAT + bcs_pkg::LANE_LAT + 3)
  ) u_dly_rad (
    .clk_i (clk_i),
    .d_i   (circle_radius_i),
    .q_o   (r_w)
  );

  logic [2:0][AXB-1:0] axp_w, axd_w;
  bcs_pkg::axis_t      axl [3];

  for (genvar k = 0; k < 3; k++) begin : g_axpack
    assign axp_w[k] = ax_w[k];
    assign axl[k]   = axd_w[k];
  end

  bcs_delay #(.WIDTH(3 * AXB), .DEPTH(5)) u_dly_axis (
    .clk_i (clk_i),
    .d_i   (axp_w),
    .q_o   (axd_w)
  );

  // ---------------- projections: four vertices and the centre on each axis
  logic signed [PW-1:0] pxq_q [3][5];
  logic signed [PW-1:0] pyq_q [3][5];
  logic signed [JW-1:0] pj_q  [3][5];
  logic signed [JW-1:0] mn01_q [3], mx01_q [3], mn23_q [3], mx23_q [3], c_q [3];
  logic signed [JW-1:0] bmin_q [3], bmax_q [3];
  logic signed [EW-1:0] cpr_q [3], cmr_q [3];
  logic signed [OW-1:0] ov_q [3];

  always_ff @(posedge clk_i) begin
    logic signed [PW:0] sum;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 5; i++) begin
        pxq_q[k][i] <= PW'($signed(cpd_w[(i < 4) ? 2*i : 8])) * PW'(ax_w[k].x);
        pyq_q[k][i] <= PW'($signed(cpd_w[(i < 4) ? 2*i+1 : 9])) * PW'(ax_w[k].y);
        sum = (PW+1)'(pxq_q[k][i]) + (PW+1)'(pyq_q[k][i]);
        // floor division by 2^15
        pj_q[k][i] <= sum[PW:15];
      end
      mn01_q[k] <= (pj_q[k][1] < pj_q[k][0]) ? pj_q[k][1] : pj_q[k][0];
      mx01_q[k] <= (pj_q[k][1] > pj_q[k][0]) ? pj_q[k][1] : pj_q[k][0];
      mn23_q[k] <= (pj_q[k][3] < pj_q[k][2]) ? pj_q[k][3] : pj_q[k][2];
      mx23_q[k] <= (pj_q[k][3] > pj_q[k][2]) ? pj_q[k][3] : pj_q[k][2];
      c_q[k]    <= pj_q[k][4];
      bmin_q[k] <= (mn23_q[k] < mn01_q[k]) ? mn23_q[k] : mn01_q[k];
      bmax_q[k] <= (mx23_q[k] > mx01_q[k]) ? mx23_q[k] : mx01_q[k];
      cpr_q[k]  <= EW'(c_q[k]) + EW'(r_w);
      cmr_q[k]  <= EW'(c_q[k]) - EW'(r_w);
    end
  end

  logic signed [EW-1:0] hi_w [3], lo_w [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hi_w[k] = (EW'(bmax_q[k]) < cpr_q[k]) ? EW'(bmax_q[k]) : cpr_q[k];
      lo_w[k] = (EW'(bmin_q[k]) > cmr_q[k]) ? EW'(bmin_q[k]) : cmr_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      ov_q[k] <= OW'(hi_w[k]) - OW'(lo_w[k]);
    end
  end

  // ---------------- smallest overlap: both edge axes compared and registered, then the vertex axis
  logic                 miss01_d, miss01_q, f01_d, f01_q;
  logic signed [OW-1:0] b01_d, b01_q, ov2_q;
  logic signed [bcs_pkg::AXIS_W-1:0] bx01_d, by01_d, bx01_q, by01_q;
  bcs_pkg::axis_t       ax2_q;

  always_comb begin
    miss01_d = (axl[0].ok && (ov_q[0][OW-1] || ov_q[0] == '0))
            || (axl[1].ok && (ov_q[1][OW-1] || ov_q[1] == '0));
    f01_d  = axl[0].ok;
    b01_d  = ov_q[0];
    bx01_d = axl[0].ok ? axl[0].x : '0;
    by01_d = axl[0].ok ? axl[0].y : '0;
    if (axl[1].ok && (!axl[0].ok || ov_q[1] < ov_q[0])) begin
      f01_d  = 1'b1;
      b01_d  = ov_q[1];
      bx01_d = axl[1].x;
      by01_d = axl[1].y;
    end
  end

  always_ff @(posedge clk_i) begin
    miss01_q <= miss01_d;
    f01_q    <= f01_d;
    b01_q    <= b01_d;
    bx01_q   <= bx01_d;
    by01_q   <= by01_d;
    ov2_q    <= ov_q[2];
    ax2_q    <= axl[2];
  end

  logic                 miss, fnd;
  logic signed [OW-1:0] best;
  logic signed [CMPW-1:0] best_x;
  logic signed [bcs_pkg::AXIS_W-1:0] bx, by;
  logic                 hit_q;
  logic [bcs_pkg::OVL_W-1:0] ovl_q;
  logic signed [bcs_pkg::AXIS_W-1:0] axx_q, axy_q;

  always_comb begin
    miss = miss01_q || (ax2_q.ok && (ov2_q[OW-1] || ov2_q == '0));
    fnd  = f01_q;
    best = b01_q;
    bx   = bx01_q;
    by   = by01_q;
    if (ax2_q.ok && (!f01_q || ov2_q < b01_q)) begin
      fnd  = 1'b1;
      best = ov2_q;
      bx   = ax2_q.x;
      by   = ax2_q.y;
    end
    best_x = CMPW'(best);
  end

  always_ff @(posedge clk_i) begin
    if (miss) begin
      hit_q <= 1'b0;
      ovl_q <= '0;
      axx_q <= '0;
      axy_q <= '0;
    end else begin
      hit_q <= 1'b1;
      ovl_q <= (!fnd || best_x > OVL_LIM) ? bcs_pkg::OVL_MAX : best_x[bcs_pkg::OVL_W-1:0];
      axx_q <= bx;
      axy_q <= by;
    end
  end

  assign hit_o     = hit_q;
  assign overlap_o = ovl_q;
  assign axis_x_o  = axx_q;
  assign axis_y_o  = axy_q;

endmodule

@@ rtl/bcs_chk.sv @@
// bcs_chk: port-level checks on the box/circle test, bound to the top level.
// Depends on bcs_pkg.
module bcs_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start_i,
  input logic                                busy_o,
  input logic                                done_o,
  input logic                                hit_o,
  input logic [bcs_pkg::OVL_W-1:0]           overlap_o,
  input logic signed [bcs_pkg::AXIS_W-1:0]   axis_x_o,
  input logic signed [bcs_pkg::AXIS_W-1:0]   axis_y_o
);

  // every result beat comes from a test taken a fixed latency before
  a_lat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, bcs_pkg::LAT))
    else $error("result beat without a matching test");

  a_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (overlap_o == '0 && axis_x_o == '0 && axis_y_o == '0))
    else $error("no-hit result carries data");

  a_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> (overlap_o != '0))
    else $error("hit with zero overlap");

  // a real unit axis is never zero, so a zero axis means no usable axis
  a_noaxis : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o && axis_x_o == '0 && axis_y_o == '0) |-> (overlap_o == bcs_pkg::OVL_MAX))
    else $error("zero axis without saturated overlap");

endmodule

bind box_circle_sat_mtv_top bcs_chk u_bcs_chk (.*);
